// ===== src/ped_pkg.sv =====
package ped_pkg;

    localparam int COORD_W = 32;            // Q16.16 coordinates and axes
    localparam int DIST_W  = 33;            // Q17.16 distance
    localparam int MUL_W   = 64;            // multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;     // full product
    localparam int WIDE_W  = 66;            // Lagrange term t + B*B and divisor
    localparam int NUM_W   = 96;            // dividend width
    localparam int QUO_W   = 32;            // quotient width
    localparam int ROOT_W  = 64;            // square root result
    localparam int RATIO_FRAC = 30;

    localparam logic [QUO_W-1:0] RATIO_CAP = QUO_W'(64'd1 << (RATIO_FRAC + 1));
    localparam logic [MUL_W-1:0] UNIT_SQ   = MUL_W'(64'd1 << (2 * RATIO_FRAC));
    localparam logic [COORD_W-1:0] AXIS_RESET = COORD_W'(32'h0001_0000);

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        CL_ERR,
        CL_YAXIS,
        CL_XAXIS,
        CL_GEN
    } t_class;

    typedef struct packed {
        t_coord u;
        t_coord v;
        t_class cls;
    } t_item;

    typedef enum logic {
        REG_MAJOR = 1'b0,
        REG_MINOR = 1'b1
    } t_reg;

    function automatic t_coord absdiff(input t_coord a, input t_coord b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // ratio saturates at 2.0 in Q2.30
    function automatic logic [QUO_W-1:0] clamp_ratio(input logic [QUO_W-1:0] r);
        clamp_ratio = (r > RATIO_CAP) ? RATIO_CAP : r;
    endfunction

endpackage

// ===== src/ped_mul.sv =====
module ped_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ped_pkg::MUL_W-1:0]   i_a,
    input  logic [ped_pkg::MUL_W-1:0]   i_b,
    output logic                        o_busy,
    output logic [ped_pkg::PROD_W-1:0]  o_prod
);
    import ped_pkg::*;

    localparam int HALF = MUL_W / 2;

    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [2:0]        r_step;
    logic              r_busy;
    logic [1:0]        r_pk;
    logic [MUL_W-1:0]  r_part;
    logic [PROD_W-1:0] r_acc;

    logic [HALF-1:0]   a_sel;
    logic [HALF-1:0]   b_sel;
    logic [PROD_W-1:0] part_sh;

    // partial product k: bit 0 picks the upper half of a, bit 1 of b
    always_comb begin
        a_sel = r_step[0] ? r_a[MUL_W-1:HALF] : r_a[HALF-1:0];
        b_sel = r_step[1] ? r_b[MUL_W-1:HALF] : r_b[HALF-1:0];
        unique case (r_pk)
            2'd0:    part_sh = {{MUL_W{1'b0}}, r_part};
            2'd3:    part_sh = {r_part, {MUL_W{1'b0}}};
            default: part_sh = {{HALF{1'b0}}, r_part, {HALF{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_step <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_step != 3'd4) begin
                r_part <= a_sel * b_sel;
                r_pk   <= r_step[1:0];
            end
            if (r_step != 3'd0) begin
                r_acc <= r_acc + part_sh;
            end
            if (r_step == 3'd4) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 3'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

// ===== src/ped_div.sv =====
module ped_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ped_pkg::NUM_W-1:0]   i_num,
    input  logic [ped_pkg::WIDE_W-1:0]  i_den,
    output logic                        o_busy,
    output logic [ped_pkg::QUO_W-1:0]   o_quo
);
    import ped_pkg::*;

    localparam int REM_W = WIDE_W + QUO_W;

    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_dsh;
    logic [QUO_W-1:0]         r_q;
    logic [$clog2(QUO_W)-1:0] r_cnt;
    logic                     r_busy;

    logic                     sat;
    logic                     fits;
    logic [REM_W-1:0]         rem_sub;

    // floor quotient, saturating when it would not fit
    assign sat     = (i_den == '0) ||
                     ({{(REM_W-NUM_W){1'b0}}, i_num} >= {i_den, {QUO_W{1'b0}}});
    assign fits    = (r_rem >= r_dsh);
    assign rem_sub = r_rem - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            if (sat) begin
                r_q    <= '1;
                r_busy <= 1'b0;
            end else begin
                r_rem  <= {{(REM_W-NUM_W){1'b0}}, i_num};
                r_dsh  <= {1'b0, i_den, {(QUO_W-1){1'b0}}};
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem_sub;
            end
            r_q   <= {r_q[QUO_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == $clog2(QUO_W)'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;

endmodule

// ===== src/ped_sqrt.sv =====
module ped_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ped_pkg::PROD_W-1:0]  i_val,
    output logic                        o_busy,
    output logic [ped_pkg::ROOT_W-1:0]  o_root
);
    import ped_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic [PROD_W-1:0]         r_n;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_W-1:0]         r_root;
    logic [$clog2(ROOT_W)-1:0] r_cnt;
    logic                      r_busy;

    logic [TRY_W-1:0]          rem2;
    logic [TRY_W-1:0]          trial;
    logic                      take;
    logic [TRY_W-1:0]          rem_sub;

    // digit-by-digit floor square root, two radicand bits per cycle
    assign rem2    = {r_rem, r_n[PROD_W-1:PROD_W-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = (rem2 >= trial);
    assign rem_sub = rem2 - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_n    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem  <= take ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], take};
            r_n    <= r_n << 2;
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == $clog2(ROOT_W)'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== src/ped_front.sv =====
module ped_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_query_x,
    input  logic [31:0]          i_query_y,
    output ped_pkg::t_coord      o_major,
    output ped_pkg::t_coord      o_minor,
    output logic                 o_item_valid,
    output ped_pkg::t_item       o_item,
    input  logic                 i_item_pop
);
    import ped_pkg::*;

    t_coord     r_major;
    t_coord     r_minor;
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_class     cls;
    logic       push;

    always_comb begin
        priority if (r_minor == '0 || r_major < r_minor) begin
            cls = CL_ERR;
        end else if (i_query_x != '0 && i_query_y != '0) begin
            cls = CL_GEN;
        end else if (i_query_y != '0) begin
            cls = CL_YAXIS;
        end else begin
            cls = CL_XAXIS;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= AXIS_RESET;
            r_minor <= AXIS_RESET;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_MAJOR: r_major <= i_cfg_data;
                    REG_MINOR: r_minor <= i_cfg_data;
                endcase
            end
            if (push) begin
                r_mem[r_wp] <= '{u: i_query_x, v: i_query_y, cls: cls};
                r_wp        <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_item_pop};
        end
    end

    assign o_major      = r_major;
    assign o_minor      = r_minor;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

endmodule

// ===== src/ped_back.sv =====
module ped_back #(
    parameter int MAX_BISECTION_STEPS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ped_pkg::t_coord              i_major,
    input  ped_pkg::t_coord              i_minor,
    input  logic                         i_item_valid,
    input  ped_pkg::t_item               i_item,
    output logic                         o_item_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [31:0]                  o_closest_x,
    output logic [31:0]                  o_closest_y,
    output logic [32:0]                  o_distance,
    output logic                         o_axis_error
);
    import ped_pkg::*;

    localparam int CNT_W = $clog2(MAX_BISECTION_STEPS + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_AA, S_BB, S_AU, S_BV, S_PREP,
        S_VV, S_UB, S_L, S_R, S_G,
        S_LINIT, S_STEP, S_SQ0, S_SQ1, S_CMP,
        S_XF, S_XD, S_YM, S_YD, S_DXY,
        S_XCHK, S_XA, S_XB, S_XC, S_XE, S_XG, S_XH, S_XI, S_XJ,
        S_H0, S_H1, S_H2, S_H3,
        S_WAIT, S_OUT
    } t_state;

    t_state            r_state;
    t_state            r_ret;
    t_class            r_cls;
    t_coord            r_u;
    t_coord            r_v;
    logic [MUL_W-1:0]  r_aa;
    logic [MUL_W-1:0]  r_bb;
    logic [MUL_W-1:0]  r_p;
    logic [MUL_W-1:0]  r_q;
    logic [MUL_W-1:0]  r_d;
    logic [MUL_W-1:0]  r_t;
    logic [MUL_W-1:0]  r_s0;
    logic [PROD_W-1:0] r_l;
    logic              r_gt;
    logic [WIDE_W-1:0] r_lo;
    logic [WIDE_W-1:0] r_hi;
    logic [WIDE_W-1:0] r_w;
    logic [WIDE_W-1:0] r_mid;
    logic [CNT_W-1:0]  r_cnt;
    t_coord            r_hx;
    t_coord            r_hy;
    t_coord            r_x;
    t_coord            r_y;
    logic [DIST_W-1:0] r_dist;
    logic              r_err;

    logic              mul_go;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              mul_busy;
    logic [PROD_W-1:0] prod;
    logic              div0_go;
    logic [NUM_W-1:0]  div0_num;
    logic [WIDE_W-1:0] div0_den;
    logic              div0_busy;
    logic [QUO_W-1:0]  quo0;
    logic              div1_go;
    logic [NUM_W-1:0]  div1_num;
    logic [WIDE_W-1:0] div1_den;
    logic              div1_busy;
    logic [QUO_W-1:0]  quo1;
    logic              sq_go;
    logic [PROD_W-1:0] sq_val;
    logic              sq_busy;
    logic [ROOT_W-1:0] root;

    logic [WIDE_W:0]   lh_sum;
    logic [WIDE_W-1:0] mid;
    logic [WIDE_W-1:0] d_wide;
    logic [QUO_W-1:0]  rat0;
    logic [QUO_W-1:0]  rat1;
    logic [MUL_W-1:0]  sq_sum;
    logic              units_busy;

    assign lh_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = lh_sum[WIDE_W:1];
    assign d_wide     = {{(WIDE_W-MUL_W){1'b0}}, r_d};
    assign rat0       = clamp_ratio(quo0);
    assign rat1       = clamp_ratio(quo1);
    assign sq_sum     = r_s0 + prod[MUL_W-1:0];
    assign units_busy = mul_busy || div0_busy || div1_busy || sq_busy;

    // operand routing for the shared units, decoded from the issuing state
    always_comb begin
        mul_go   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div0_go  = 1'b0;
        div0_num = '0;
        div0_den = '0;
        div1_go  = 1'b0;
        div1_num = '0;
        div1_den = '0;
        sq_go    = 1'b0;
        sq_val   = '0;
        unique case (r_state)
            S_AA: begin
                mul_go = 1'b1; mul_a = MUL_W'(i_major); mul_b = MUL_W'(i_major);
            end
            S_BB: begin
                mul_go = 1'b1; mul_a = MUL_W'(i_minor); mul_b = MUL_W'(i_minor);
            end
            S_AU: begin
                mul_go = 1'b1; mul_a = MUL_W'(i_major); mul_b = MUL_W'(r_u);
            end
            S_BV: begin
                mul_go = 1'b1; mul_a = MUL_W'(i_minor); mul_b = MUL_W'(r_v);
            end
            S_VV: begin
                mul_go = 1'b1; mul_a = MUL_W'(r_v); mul_b = MUL_W'(r_v);
            end
            S_UB: begin
                mul_go = 1'b1; mul_a = MUL_W'(r_u); mul_b = MUL_W'(i_minor);
            end
            S_L: begin
                mul_go = 1'b1; mul_a = prod[MUL_W-1:0]; mul_b = prod[MUL_W-1:0];
            end
            S_R: begin
                mul_go = 1'b1; mul_a = r_aa; mul_b = r_t;
            end
            S_STEP: begin
                if (r_cnt != CNT_W'(MAX_BISECTION_STEPS) && mid != r_lo && mid != r_hi) begin
                    div0_go  = 1'b1;
                    div0_num = {{(NUM_W-MUL_W-RATIO_FRAC){1'b0}}, r_p, {RATIO_FRAC{1'b0}}};
                    div0_den = mid + d_wide;
                    div1_go  = 1'b1;
                    div1_num = {{(NUM_W-MUL_W-RATIO_FRAC){1'b0}}, r_q, {RATIO_FRAC{1'b0}}};
                    div1_den = mid;
                end
            end
            S_SQ0: begin
                mul_go = 1'b1; mul_a = MUL_W'(rat0); mul_b = MUL_W'(rat0);
            end
            S_SQ1: begin
                mul_go = 1'b1; mul_a = MUL_W'(rat1); mul_b = MUL_W'(rat1);
            end
            S_XF, S_XA: begin
                mul_go = 1'b1; mul_a = r_aa; mul_b = MUL_W'(r_u);
            end
            S_XD: begin
                div0_go = 1'b1; div0_num = prod[NUM_W-1:0]; div0_den = r_w + d_wide;
            end
            S_YM: begin
                mul_go = 1'b1; mul_a = r_bb; mul_b = MUL_W'(r_v);
            end
            S_YD: begin
                div0_go = 1'b1; div0_num = prod[NUM_W-1:0]; div0_den = r_w;
            end
            S_XB, S_XI: begin
                div0_go = 1'b1; div0_num = prod[NUM_W-1:0]; div0_den = d_wide;
            end
            S_XC: begin
                mul_go = 1'b1; mul_a = r_d; mul_b = r_d;
            end
            S_XE: begin
                mul_go = 1'b1; mul_a = r_p; mul_b = r_p;
            end
            S_XG: begin
                sq_go = 1'b1; sq_val = r_l - prod;
            end
            S_XH: begin
                mul_go = 1'b1; mul_a = MUL_W'(i_minor); mul_b = root;
            end
            S_H0: begin
                mul_go = 1'b1; mul_a = MUL_W'(r_hx); mul_b = MUL_W'(r_hx);
            end
            S_H1: begin
                mul_go = 1'b1; mul_a = MUL_W'(r_hy); mul_b = MUL_W'(r_hy);
            end
            S_H2: begin
                sq_go = 1'b1; sq_val = r_l + prod;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_u   <= i_item.u;
                        r_v   <= i_item.v;
                        r_cls <= i_item.cls;
                        unique case (i_item.cls)
                            CL_ERR: begin
                                r_x <= '0; r_y <= '0; r_dist <= '0; r_err <= 1'b1;
                                r_state <= S_OUT;
                            end
                            CL_YAXIS: begin
                                r_x <= '0; r_y <= i_minor; r_err <= 1'b0;
                                r_dist  <= DIST_W'(absdiff(i_item.v, i_minor));
                                r_state <= S_OUT;
                            end
                            CL_XAXIS, CL_GEN: begin
                                r_err   <= 1'b0;
                                r_state <= S_AA;
                            end
                        endcase
                    end
                end
                S_AA: begin
                    r_ret <= S_BB; r_state <= S_WAIT;
                end
                S_BB: begin
                    r_aa <= prod[MUL_W-1:0]; r_ret <= S_AU; r_state <= S_WAIT;
                end
                S_AU: begin
                    r_bb <= prod[MUL_W-1:0]; r_ret <= S_BV; r_state <= S_WAIT;
                end
                S_BV: begin
                    r_p <= prod[MUL_W-1:0]; r_ret <= S_PREP; r_state <= S_WAIT;
                end
                S_PREP: begin
                    r_q <= prod[MUL_W-1:0];
                    r_d <= r_aa - r_bb;
                    priority if (r_cls == CL_XAXIS) begin
                        r_state <= S_XCHK;
                    end else if (r_v < i_minor) begin
                        r_state <= S_VV;
                    end else begin
                        r_gt    <= 1'b1;
                        r_state <= S_LINIT;
                    end
                end
                S_VV: begin
                    r_ret <= S_UB; r_state <= S_WAIT;
                end
                S_UB: begin
                    r_t <= r_bb - prod[MUL_W-1:0]; r_ret <= S_L; r_state <= S_WAIT;
                end
                S_L: begin
                    r_ret <= S_R; r_state <= S_WAIT;
                end
                S_R: begin
                    r_l <= prod; r_ret <= S_G; r_state <= S_WAIT;
                end
                S_G: begin
                    if (r_l == prod) begin
                        // query lies on the ellipse
                        r_x <= r_u; r_y <= r_v; r_dist <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_gt    <= (r_l > prod);
                        r_state <= S_LINIT;
                    end
                end
                S_LINIT: begin
                    r_lo    <= WIDE_W'(r_q);
                    r_hi    <= r_gt ? (WIDE_W'(r_p) + WIDE_W'(r_q)) : WIDE_W'(r_bb);
                    r_w     <= WIDE_W'(r_q);
                    r_cnt   <= '0;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_cnt == CNT_W'(MAX_BISECTION_STEPS)) begin
                        r_state <= S_XF;
                    end else begin
                        r_w <= mid;
                        if (mid == r_lo || mid == r_hi) begin
                            r_state <= S_XF;
                        end else begin
                            r_mid   <= mid;
                            r_cnt   <= r_cnt + 1'b1;
                            r_ret   <= S_SQ0;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_SQ0: begin
                    r_ret <= S_SQ1; r_state <= S_WAIT;
                end
                S_SQ1: begin
                    r_s0 <= prod[MUL_W-1:0]; r_ret <= S_CMP; r_state <= S_WAIT;
                end
                S_CMP: begin
                    priority if (sq_sum > UNIT_SQ) begin
                        r_lo    <= r_mid;
                        r_state <= S_STEP;
                    end else if (sq_sum < UNIT_SQ) begin
                        r_hi    <= r_mid;
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_XF;
                    end
                end
                S_XF: begin
                    r_ret <= S_XD; r_state <= S_WAIT;
                end
                S_XD: begin
                    r_ret <= S_YM; r_state <= S_WAIT;
                end
                S_YM: begin
                    r_x <= quo0; r_ret <= S_YD; r_state <= S_WAIT;
                end
                S_YD: begin
                    r_ret <= S_DXY; r_state <= S_WAIT;
                end
                S_DXY: begin
                    r_y     <= quo0;
                    r_hx    <= absdiff(r_x, r_u);
                    r_hy    <= absdiff(quo0, r_v);
                    r_state <= S_H0;
                end
                S_XCHK: begin
                    if (r_p < r_d) begin
                        // query lies below (major^2 - minor^2) / major on the major axis
                        r_state <= S_XA;
                    end else begin
                        r_x <= i_major; r_y <= '0;
                        r_dist  <= DIST_W'(absdiff(r_u, i_major));
                        r_state <= S_OUT;
                    end
                end
                S_XA: begin
                    r_ret <= S_XB; r_state <= S_WAIT;
                end
                S_XB: begin
                    r_ret <= S_XC; r_state <= S_WAIT;
                end
                S_XC: begin
                    r_x <= quo0; r_ret <= S_XE; r_state <= S_WAIT;
                end
                S_XE: begin
                    r_l <= prod; r_ret <= S_XG; r_state <= S_WAIT;
                end
                S_XG: begin
                    r_ret <= S_XH; r_state <= S_WAIT;
                end
                S_XH: begin
                    r_ret <= S_XI; r_state <= S_WAIT;
                end
                S_XI: begin
                    r_ret <= S_XJ; r_state <= S_WAIT;
                end
                S_XJ: begin
                    r_y     <= quo0;
                    r_hx    <= absdiff(r_x, r_u);
                    r_hy    <= quo0;
                    r_state <= S_H0;
                end
                S_H0: begin
                    r_ret <= S_H1; r_state <= S_WAIT;
                end
                S_H1: begin
                    r_l <= prod; r_ret <= S_H2; r_state <= S_WAIT;
                end
                S_H2: begin
                    r_ret <= S_H3; r_state <= S_WAIT;
                end
                S_H3: begin
                    r_dist  <= root[DIST_W-1:0];
                    r_state <= S_OUT;
                end
                S_WAIT: begin
                    if (!units_busy) begin
                        r_state <= r_ret;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    ped_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (prod)
    );

    ped_div u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div0_go),
        .i_num   (div0_num),
        .i_den   (div0_den),
        .o_busy  (div0_busy),
        .o_quo   (quo0)
    );

    ped_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div1_go),
        .i_num   (div1_num),
        .i_den   (div1_den),
        .o_busy  (div1_busy),
        .o_quo   (quo1)
    );

    ped_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_go),
        .i_val   (sq_val),
        .o_busy  (sq_busy),
        .o_root  (root)
    );

    assign o_item_pop   = (r_state == S_IDLE) && i_item_valid;
    assign o_valid      = (r_state == S_OUT);
    assign o_closest_x  = r_x;
    assign o_closest_y  = r_y;
    assign o_distance   = r_dist;
    assign o_axis_error = r_err;

endmodule

// ===== src/point_ellipse_distance_top.sv =====
// Nearest point on an axis-aligned ellipse centred at the origin, and the
// distance to it, for a first-quadrant query (Q16.16 in, Q16.16/Q17.16 out).
// Config: write semi_major (index 0) and semi_minor (index 1) on the cfg
//   channel while the block is idle; o_cfg_ready is always high. Bad axes
//   (minor zero or major below minor) give o_axis_error and zero outputs.
// Input: one query word per i_valid/o_ready handshake. A two-word queue
//   sits after the classifier, so up to two queries can enter while the
//   solver works or its result waits.
// Output: one result word per o_valid/i_ready handshake; the result stays
//   registered until taken and the solver holds meanwhile.
// Solver: error and y-axis queries go straight to the result; x-axis and
//   general queries use the shared arithmetic units, general ones with up
//   to 64 bisection steps. Throughput is one item at a time, set by the
//   shared multiplier, the two 32-step dividers run side by side, and the
//   64-step square root unit.
// Reset (synchronous, active low): both axes return to 1.0, queue empties,
//   solver goes idle.
module point_ellipse_distance_top #(
    parameter int MAX_BISECTION_STEPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_query_x,
    input  logic [31:0] i_query_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_closest_x,
    output logic [31:0] o_closest_y,
    output logic [32:0] o_distance,
    output logic        o_axis_error
);
    import ped_pkg::*;

    t_coord major;
    t_coord minor;
    logic   item_valid;
    t_item  item;
    logic   item_pop;

    // front: config registers, classification, queue
    ped_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_query_x    (i_query_x),
        .i_query_y    (i_query_y),
        .o_major      (major),
        .o_minor      (minor),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // back: sequenced solver over shared arithmetic units
    ped_back #(
        .MAX_BISECTION_STEPS (MAX_BISECTION_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_major      (major),
        .i_minor      (minor),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_closest_x  (o_closest_x),
        .o_closest_y  (o_closest_y),
        .o_distance   (o_distance),
        .o_axis_error (o_axis_error)
    );

endmodule
